FILE: rtl/fat_short_name_lookup_top_assert.svh
// Assertion macros shared by the lookup checker.
`ifndef FAT_SHORT_NAME_LOOKUP_TOP_ASSERT_SVH
`define FAT_SHORT_NAME_LOOKUP_TOP_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define FSNL_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define FSNL_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/fsnl_pkg.sv
package fsnl_pkg;

  localparam int NameLen   = 11;
  localparam int ExtPos    = 8;
  localparam int NamePosW  = 4;
  localparam int MaxEntW   = 11;
  localparam int IndexW    = 11;
  localparam int FuncW     = 2;
  localparam int PosW      = 5;
  localparam int StatusW   = 3;
  localparam int InDataW   = 16;
  localparam int OutDataW  = 16;
  localparam int ApbAddrW  = 3;
  localparam int ApbDataW  = 32;

  localparam logic [MaxEntW-1:0] MaxEntReset = MaxEntW'(224);

  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharDot   = 8'h2e;
  localparam logic [7:0] CharLowA  = 8'h61;
  localparam logic [7:0] CharLowZ  = 8'h7a;
  localparam logic [7:0] CharNul   = 8'h00;
  localparam logic [7:0] AttrDirVol = 8'h18;
  localparam logic [7:0] CaseOffset = 8'h20;

  localparam logic [PosW-1:0] PosFirst = PosW'(0);
  localparam logic [PosW-1:0] PosType  = PosW'(NameLen);

  localparam logic [0:0] RegMaxEntries = 1'b0;

  typedef enum logic [FuncW-1:0] {
    FUNC_NEW   = 2'd0,
    FUNC_CHAR  = 2'd1,
    FUNC_ENTRY = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef enum logic [StatusW-1:0] {
    ST_CHECKED  = 3'd0,
    ST_FOUND    = 3'd1,
    ST_END      = 3'd2,
    ST_LIMIT    = 3'd3,
    ST_BAD_NAME = 3'd4
  } status_e;

  typedef logic [7:0] name_t [NameLen];

endpackage

FILE: rtl/fat_short_name_lookup_top.sv
// FAT 8.3 short-name lookup over a streamed root directory.
// Input stream: tuser carries the item kind (new search, name character,
// directory entry byte); tdata carries the byte and its offset in the entry.
// A search starts with a new-search transaction, then the name characters,
// then the directory bytes. Only entry bytes 0 and 11 can produce a result:
// end marker, entry limit or bad name at byte 0, found or checked at byte 11.
// Output stream: tuser is the status, tdata the entry index it refers to.
// Each input transaction is handled in the cycle it is accepted; its result,
// if any, shows on the output in the next cycle from the output register.
// Throughput is one transaction per cycle while the output is drained; the
// input is ready whenever the output register is empty or being taken, so a
// stalled receiver holds at most one result and stalls the input after it.
// The entry limit register is written over the APB port and reads back.
// Reset sets the entry limit to 224, clears the output register and leaves
// the search finished, so entry bytes are ignored until a new search.
module fat_short_name_lookup_top #(
  parameter int ENTRY_LIMIT = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // [7:0] data, [12:8] byte_pos, [15:13] zero
  input  logic [fsnl_pkg::InDataW-1:0]      s_axis_tdata_i,
  // [1:0] func
  input  logic [fsnl_pkg::FuncW-1:0]        s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // [10:0] entry_index, [15:11] zero
  output logic [fsnl_pkg::OutDataW-1:0]     m_axis_tdata_o,
  // [2:0] status
  output logic [fsnl_pkg::StatusW-1:0]      m_axis_tuser_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [fsnl_pkg::ApbAddrW-1:0]     paddr,
  input  logic [fsnl_pkg::ApbDataW-1:0]     pwdata,
  output logic [fsnl_pkg::ApbDataW-1:0]     prdata,
  output logic                              pready
);
  import fsnl_pkg::*;

  localparam int CntW = $clog2(ENTRY_LIMIT + 1);
  localparam int XW   = (CntW > MaxEntW) ? CntW : MaxEntW;

  logic [MaxEntW-1:0]  max_ent_q;
  name_t               name_q, name_d;
  logic [NamePosW-1:0] npos_q, npos_d;
  logic                bad_q, bad_d;
  logic                mism_q, mism_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                done_q, done_d;

  logic                out_valid_q;
  status_e             out_status_q;
  logic [IndexW-1:0]   out_index_q;

  logic                in_acc;
  logic [7:0]          in_data;
  logic [PosW-1:0]     in_pos;
  func_e               in_func;
  logic [7:0]          chr;
  logic [7:0]          name_sel;
  logic                res_valid;
  status_e             res_status;
  logic [XW-1:0]       cnt_ext;
  logic [XW-1:0]       max_ext;
  logic                at_limit;
  logic                cfg_wr;

  assign in_data  = s_axis_tdata_i[7:0];
  assign in_pos   = s_axis_tdata_i[12:8];
  assign in_func  = func_e'(s_axis_tuser_i);
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;

  assign cnt_ext  = XW'(cnt_q);
  assign max_ext  = XW'(max_ent_q);
  assign at_limit = (cnt_ext >= max_ext) || (cnt_q >= CntW'(ENTRY_LIMIT));

  always_comb begin
    name_sel = CharSpace;
    for (int i = 0; i < NameLen; i++) begin
      if (in_pos == PosW'(i)) begin
        name_sel = name_q[i];
      end
    end
  end

  always_comb begin
    chr = in_data;
    if (in_data >= CharLowA && in_data <= CharLowZ) begin
      chr = in_data - CaseOffset;
    end
  end

  always_comb begin
    name_d     = name_q;
    npos_d     = npos_q;
    bad_d      = bad_q;
    mism_d     = mism_q;
    cnt_d      = cnt_q;
    done_d     = done_q;
    res_valid  = 1'b0;
    res_status = ST_CHECKED;
    if (in_acc) begin
      case (in_func)
        FUNC_NEW: begin
          for (int i = 0; i < NameLen; i++) begin
            name_d[i] = CharSpace;
          end
          npos_d = '0;
          bad_d  = 1'b0;
          mism_d = 1'b0;
          cnt_d  = '0;
          done_d = 1'b0;
        end
        FUNC_CHAR: begin
          if (in_data != CharNul) begin
            if (npos_q >= NamePosW'(NameLen)) begin
              bad_d = 1'b1;
            end else if (in_data == CharDot && npos_q <= NamePosW'(ExtPos)) begin
              npos_d = NamePosW'(ExtPos);
            end else begin
              for (int i = 0; i < NameLen; i++) begin
                if (npos_q == NamePosW'(i)) begin
                  name_d[i] = chr;
                end
              end
              npos_d = npos_q + 1'b1;
            end
          end
        end
        FUNC_ENTRY: begin
          if (!done_q) begin
            if (in_pos == PosFirst) begin
              if (bad_q) begin
                done_d = 1'b1; res_valid = 1'b1; res_status = ST_BAD_NAME;
              end else if (at_limit) begin
                done_d = 1'b1; res_valid = 1'b1; res_status = ST_LIMIT;
              end else if (in_data == CharNul) begin
                done_d = 1'b1; res_valid = 1'b1; res_status = ST_END;
              end else begin
                mism_d = (in_data != name_sel);
              end
            end else if (in_pos < PosType) begin
              if (in_data != name_sel) begin
                mism_d = 1'b1;
              end
            end else if (in_pos == PosType) begin
              res_valid = 1'b1;
              if ((in_data & AttrDirVol) == 8'h00 && !mism_q) begin
                done_d     = 1'b1;
                res_status = ST_FOUND;
              end else begin
                res_status = ST_CHECKED;
                if (cnt_q < CntW'(ENTRY_LIMIT)) begin
                  cnt_d = cnt_q + 1'b1;
                end
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NameLen; i++) begin
        name_q[i] <= CharSpace;
      end
      npos_q <= '0;
      bad_q  <= 1'b0;
      mism_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b1;
    end else begin
      name_q <= name_d;
      npos_q <= npos_d;
      bad_q  <= bad_d;
      mism_q <= mism_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  // Output register: loaded by a result, emptied when the receiver takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_status_q <= res_status;
      out_index_q  <= cnt_ext[IndexW-1:0];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tdata_o  = OutDataW'(out_index_q);

  // APB register file.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_ent_q <= MaxEntReset;
    end else if (cfg_wr && paddr[2] == RegMaxEntries) begin
      max_ent_q <= pwdata[MaxEntW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == RegMaxEntries) begin
      prdata = ApbDataW'(max_ent_q);
    end
  end

endmodule

FILE: rtl/fsnl_checker.sv
`include "fat_short_name_lookup_top_assert.svh"

module fsnl_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid_i,
  input logic                          s_axis_tready_o,
  input logic [fsnl_pkg::InDataW-1:0]  s_axis_tdata_i,
  input logic [fsnl_pkg::FuncW-1:0]    s_axis_tuser_i,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [fsnl_pkg::OutDataW-1:0] m_axis_tdata_o,
  input logic [fsnl_pkg::StatusW-1:0]  m_axis_tuser_o
);
  import fsnl_pkg::*;

  logic in_acc;
  logic out_free;
  logic no_result_item;

  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !m_axis_tvalid_o || m_axis_tready_i;
  // Only entry bytes 0 and 11 can produce a result.
  assign no_result_item = (s_axis_tuser_i != FUNC_ENTRY) ||
                          (s_axis_tdata_i[12:8] != PosFirst &&
                           s_axis_tdata_i[12:8] != PosType);

  `FSNL_ASSERT_NEXT(a_out_hold, clk_i, rst_ni,
                    m_axis_tvalid_o && !m_axis_tready_i,
                    m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o),
                    "stalled result changed")

  `FSNL_ASSERT(a_ready_when_empty, clk_i, rst_ni,
               !m_axis_tvalid_o |-> s_axis_tready_o,
               "input not ready with empty output register")

  `FSNL_ASSERT_NEXT(a_no_spurious_result, clk_i, rst_ni,
                    in_acc && no_result_item && out_free,
                    !m_axis_tvalid_o,
                    "result produced by a transaction that cannot cause one")

endmodule

bind fat_short_name_lookup_top fsnl_checker u_fsnl_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
